// ===== rtl/wsfb_pkg.sv =====
// Shared types and constants for the WebSocket frame builder.
// No dependencies; wsfb_front, wsfb_queue, wsfb_back and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package wsfb_pkg;

  typedef enum logic [1:0] {
    CMD_HEADER = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_ERROR  = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    LEN_SHORT = 2'd0,
    LEN_16    = 2'd1,
    LEN_64    = 2'd2
  } len_form_t;

  localparam logic [62:0] LEN16_MAX   = 63'h0000_0000_0000_FFFF;
  localparam logic [6:0]  LEN_CODE_16 = 7'd126;
  localparam logic [6:0]  LEN_CODE_64 = 7'd127;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic        last;
    logic [62:0] frame_len;
    logic        mask_enable;
    logic [31:0] mask_key;
    len_form_t   len_form;
    logic [3:0]  final_index;
    logic [63:0] total_length;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/wsfb_item_if.sv =====
// Input channel of the frame builder: valid/ready handshake and item fields.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface wsfb_item_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  flags;
  logic [62:0] frame_len;
  logic        mask_enable;
  logic [31:0] mask_key;
  logic [7:0]  data_byte;

  modport source (
    output valid, req_type, flags, frame_len, mask_enable, mask_key, data_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, flags, frame_len, mask_enable, mask_key, data_byte,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/wsfb_result_if.sv =====
// Output channel of the frame builder: valid/ready handshake and result fields.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface wsfb_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last;
  logic        error;
  logic [63:0] total_length;

  modport source (
    output valid, out_byte, last, error, total_length,
    input  ready
  );
  modport sink (
    input  valid, out_byte, last, error, total_length,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/wsfb_front.sv =====
// Front end: accepts input beats, tracks the open frame and issues commands.
// Depends on wsfb_pkg and wsfb_item_if.
`timescale 1ns / 1ps
`default_nettype none

module wsfb_front
  import wsfb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  wsfb_item_if.sink item,
  output cmd_t      cmd,
  output logic      cmd_valid,
  input  wire logic cmd_ready
);

  logic [62:0] bytes_left;
  logic [31:0] key_word;
  logic        masking_on;
  logic [1:0]  key_phase;
  logic        frame_open;

  logic        accept;
  logic        len_big;
  logic        len_mid;
  logic [3:0]  hdr_count;
  logic [62:0] left_dec;
  logic [7:0]  key_byte;

  assign item.ready = cmd_ready;
  assign cmd_valid  = item.valid;
  assign accept     = item.valid && cmd_ready;

  assign len_big   = item.frame_len > LEN16_MAX;
  assign len_mid   = item.frame_len >= {56'd0, LEN_CODE_16};
  assign hdr_count = 4'd2 + (len_big ? 4'd8 : (len_mid ? 4'd2 : 4'd0))
                   + (item.mask_enable ? 4'd4 : 4'd0);
  assign left_dec  = bytes_left - 63'd1;
  assign key_byte  = 8'(key_word >> {~key_phase, 3'b000});

  always_comb begin
    cmd = '0;
    if (!item.req_type) begin
      cmd.kind         = CMD_HEADER;
      cmd.data         = item.flags;
      cmd.last         = (item.frame_len == 63'd0);
      cmd.frame_len    = item.frame_len;
      cmd.mask_enable  = item.mask_enable;
      cmd.mask_key     = item.mask_key;
      cmd.len_form     = len_big ? LEN_64 : (len_mid ? LEN_16 : LEN_SHORT);
      cmd.final_index  = hdr_count - 4'd1;
      cmd.total_length = {1'b0, item.frame_len} + {60'd0, hdr_count};
    end else if (!frame_open) begin
      cmd.kind = CMD_ERROR;
      cmd.last = 1'b1;
    end else begin
      cmd.kind = CMD_DATA;
      cmd.data = item.data_byte ^ (masking_on ? key_byte : 8'd0);
      cmd.last = (left_dec == 63'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
      key_word   <= '0;
      masking_on <= 1'b0;
      key_phase  <= '0;
      frame_open <= 1'b0;
    end else if (accept) begin
      if (!item.req_type) begin
        bytes_left <= item.frame_len;
        key_word   <= item.mask_enable ? item.mask_key : 32'd0;
        masking_on <= item.mask_enable;
        key_phase  <= '0;
        frame_open <= (item.frame_len != 63'd0);
      end else if (frame_open) begin
        bytes_left <= left_dec;
        key_phase  <= key_phase + 2'd1;
        if (left_dec == 63'd0) begin
          frame_open <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wsfb_queue.sv =====
// Short command queue between the front end and the serializer.
// Depends on wsfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsfb_queue
  import wsfb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t push_cmd,
  input  wire logic push_valid,
  output logic      push_ready,
  output cmd_t      head_cmd,
  output logic      head_valid,
  input  wire logic pop
);

  cmd_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QUEUE_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wsfb_back.sv =====
// Back end: serializes queued commands into output beats through a result register.
// Depends on wsfb_pkg and wsfb_result_if.
`timescale 1ns / 1ps
`default_nettype none

module wsfb_back
  import wsfb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cmd_t   head_cmd,
  input  wire logic   head_valid,
  output logic        pop,
  wsfb_result_if.source result
);

  logic [3:0]  index;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_error;
  logic [63:0] out_total;

  logic        load;
  logic        final_beat;
  logic [7:0]  gen_byte;
  logic        gen_last;
  logic        gen_error;
  logic [63:0] gen_total;
  logic [3:0]  len_count;
  logic [6:0]  len_code;
  logic [3:0]  rel;
  logic [3:0]  key_pos;
  logic [3:0]  len_shift;

  assign result.valid        = out_valid;
  assign result.out_byte     = out_byte;
  assign result.last         = out_last;
  assign result.error        = out_error;
  assign result.total_length = out_total;

  assign load = head_valid && (!out_valid || result.ready);
  assign pop  = load && final_beat;

  always_comb begin
    unique case (head_cmd.len_form)
      LEN_64: begin
        len_count = 4'd8;
        len_code  = LEN_CODE_64;
      end
      LEN_16: begin
        len_count = 4'd2;
        len_code  = LEN_CODE_16;
      end
      default: begin
        len_count = 4'd0;
        len_code  = head_cmd.frame_len[6:0];
      end
    endcase
  end

  assign rel       = index - 4'd2;
  assign key_pos   = rel - len_count;
  assign len_shift = len_count - 4'd1 - rel;

  always_comb begin
    gen_byte   = 8'd0;
    gen_last   = 1'b0;
    gen_error  = 1'b0;
    gen_total  = 64'd0;
    final_beat = 1'b1;
    unique case (head_cmd.kind)
      CMD_HEADER: begin
        final_beat = (index == head_cmd.final_index);
        gen_last   = final_beat && head_cmd.last;
        gen_total  = head_cmd.total_length;
        if (index == 4'd0) begin
          gen_byte = head_cmd.data;
        end else if (index == 4'd1) begin
          gen_byte = {head_cmd.mask_enable, len_code};
        end else if (rel < len_count) begin
          gen_byte = 8'({1'b0, head_cmd.frame_len} >> {len_shift[2:0], 3'b000});
        end else begin
          gen_byte = 8'(head_cmd.mask_key >> {~key_pos[1:0], 3'b000});
        end
      end
      CMD_DATA: begin
        gen_byte = head_cmd.data;
        gen_last = head_cmd.last;
      end
      default: begin
        gen_last  = 1'b1;
        gen_error = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      index     <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        index     <= final_beat ? 4'd0 : index + 4'd1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= gen_byte;
      out_last  <= gen_last;
      out_error <= gen_error;
      out_total <= gen_total;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/websocket_frame_builder_core.sv =====
// Top level of the WebSocket frame builder: front end, command queue and serializer.
// Depends on wsfb_pkg, wsfb_item_if, wsfb_result_if, wsfb_front, wsfb_queue and wsfb_back.
`timescale 1ns / 1ps
`default_nettype none

// The block turns header and payload items into an RFC 6455 frame byte stream, one
// output beat per byte. An input item is taken whenever the four-entry command
// queue has room, so payload bytes stream at one byte per cycle while the output side
// is not stalled. A header item yields 2 to 14 output beats (2, 4 or 10 bytes of flags
// and length, plus 4 key bytes when masked), during which later items collect in the queue.
// An orphan payload byte yields a single error beat. Each item passes through a queue
// entry register and then the result register on its way to the output.

module websocket_frame_builder_core
  import wsfb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  wsfb_item_if.sink     item,
  wsfb_result_if.source result
);

  cmd_t front_cmd;
  logic front_valid;
  logic queue_ready;
  cmd_t head_cmd;
  logic head_valid;
  logic pop;

  wsfb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (queue_ready)
  );

  wsfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (front_cmd),
    .push_valid (front_valid),
    .push_ready (queue_ready),
    .head_cmd   (head_cmd),
    .head_valid (head_valid),
    .pop        (pop)
  );

  wsfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_cmd   (head_cmd),
    .head_valid (head_valid),
    .pop        (pop),
    .result     (result)
  );

  a_reset_idle: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("Result beat presented right after reset.");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.error |->
      result.last && result.out_byte == 8'd0 && result.total_length == 64'd0)
    else $error("Error beat carries data or is not marked last.");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("Serializer consumed an empty queue slot.");

endmodule

`default_nettype wire
